FILE: sv/glos_pkg.sv
package glos_pkg;

  localparam int MAP_ROWS_DEF = 256;
  localparam int MAP_COLS_DEF = 256;

  localparam int COORD_W     = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 1;
  // decision term: covers +/- 2 * (2^COORD_W - 1)
  localparam int DELTA_W     = COORD_W + 3;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 9'd256;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 9'd256;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic KIND_WRITE = 1'b0;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
    logic               occupied;
  } item_t;

  typedef struct packed {
    logic line_clear;
    logic out_of_range;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_BASE,
    ST_WRITE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic base;
    logic mem_write;
    logic step;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic is_write;
    logic write_ok;
    logic oor;
    logic last;
    logic res_free;
  } status_t;

endpackage

FILE: sv/glos_ctrl.sv
module glos_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  glos_pkg::status_t status,
  output glos_pkg::ctrl_t   ctrl
);

  glos_pkg::state_t state;
  glos_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glos_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      glos_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = glos_pkg::ST_CALC;
      end
      glos_pkg::ST_CALC: begin
        state_next = glos_pkg::ST_BASE;
      end
      glos_pkg::ST_BASE: begin
        if (status.is_write) begin
          state_next = status.write_ok ? glos_pkg::ST_WRITE : glos_pkg::ST_IDLE;
        end else begin
          state_next = status.oor ? glos_pkg::ST_FINISH : glos_pkg::ST_WALK;
        end
      end
      glos_pkg::ST_WRITE: begin
        state_next = glos_pkg::ST_IDLE;
      end
      glos_pkg::ST_WALK: begin
        if (status.last) state_next = glos_pkg::ST_DRAIN;
      end
      glos_pkg::ST_DRAIN: begin
        state_next = glos_pkg::ST_FINISH;
      end
      glos_pkg::ST_FINISH: begin
        if (status.res_free) state_next = glos_pkg::ST_IDLE;
      end
      default: begin
        state_next = glos_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl      = '0;
    cmd_stall = 1'b1;
    unique case (state)
      glos_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        ctrl.load = cmd_valid;
      end
      glos_pkg::ST_CALC:   ctrl.calc = 1'b1;
      glos_pkg::ST_BASE:   ctrl.base = 1'b1;
      glos_pkg::ST_WRITE:  ctrl.mem_write = 1'b1;
      glos_pkg::ST_WALK:   ctrl.step = 1'b1;
      glos_pkg::ST_DRAIN: begin
      end
      glos_pkg::ST_FINISH: ctrl.emit = status.res_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/glos_datapath.sv
module glos_datapath #(
  parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = glos_pkg::MAP_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  glos_pkg::item_t                      cmd,
  input  logic                                 cfg_we,
  input  logic [glos_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]           cfg_data,
  input  glos_pkg::ctrl_t                      ctrl,
  output glos_pkg::status_t                    status,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output glos_pkg::result_t                    res
);

  localparam int DEPTH = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAP_ROWS + 1);
  localparam int CW    = $clog2(MAP_COLS + 1);
  localparam int XW    = glos_pkg::COORD_W;
  localparam int DW    = glos_pkg::DELTA_W;

  logic [glos_pkg::CFG_W-1:0] row_count;
  logic [glos_pkg::CFG_W-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= glos_pkg::ROW_COUNT_RST;
      col_count <= glos_pkg::COL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glos_pkg::REG_ROW_COUNT: row_count <= cfg_data;
        glos_pkg::REG_COL_COUNT: col_count <= cfg_data;
      endcase
    end
  end

  // zero acts as one, anything above the map size acts as the map size
  logic [RW-1:0] rows_eff;
  logic [CW-1:0] cols_eff;

  always_comb begin
    if (row_count == '0) begin
      rows_eff = RW'(1);
    end else if (32'(row_count) > MAP_ROWS) begin
      rows_eff = RW'(MAP_ROWS);
    end else begin
      rows_eff = RW'(row_count);
    end
    if (col_count == '0) begin
      cols_eff = CW'(1);
    end else if (32'(col_count) > MAP_COLS) begin
      cols_eff = CW'(MAP_COLS);
    end else begin
      cols_eff = CW'(col_count);
    end
  end

  glos_pkg::item_t item_q;

  always_ff @(posedge clk) begin
    if (ctrl.load) item_q <= cmd;
  end

  // line geometry from the captured transaction
  logic                 r_up;
  logic                 c_up;
  logic [XW-1:0]        adr;
  logic [XW-1:0]        adc;
  logic                 row_major;
  logic [XW-1:0]        major_c;
  logic [XW-1:0]        minor_c;
  logic                 start_ok;
  logic                 end_ok;
  logic [AW-1:0]        row_step;
  logic [AW-1:0]        col_step;
  logic signed [DW-1:0] d_init_c;
  logic signed [DW-1:0] inc_diag_c;
  logic signed [DW-1:0] inc_straight_c;

  always_comb begin
    r_up      = item_q.end_row > item_q.start_row;
    c_up      = item_q.end_col > item_q.start_col;
    adr       = r_up ? item_q.end_row - item_q.start_row : item_q.start_row - item_q.end_row;
    adc       = c_up ? item_q.end_col - item_q.start_col : item_q.start_col - item_q.end_col;
    row_major = adr > adc;
    major_c   = row_major ? adr : adc;
    minor_c   = row_major ? adc : adr;
    start_ok  = (32'(item_q.start_row) < 32'(rows_eff)) &&
                (32'(item_q.start_col) < 32'(cols_eff));
    end_ok    = (32'(item_q.end_row) < 32'(rows_eff)) &&
                (32'(item_q.end_col) < 32'(cols_eff));
    row_step  = r_up ? AW'(cols_eff) : AW'(0) - AW'(cols_eff);
    col_step  = c_up ? AW'(1) : {AW{1'b1}};
    inc_straight_c = $signed({2'b00, minor_c, 1'b0});
    inc_diag_c     = $signed({2'b00, minor_c, 1'b0}) - $signed({2'b00, major_c, 1'b0});
    d_init_c       = $signed({2'b00, minor_c, 1'b0}) - $signed({3'b000, major_c});
  end

  logic                 write_ok;
  logic                 oor;
  logic [XW-1:0]        major;
  logic [AW-1:0]        maj_step;
  logic [AW-1:0]        min_step;
  logic [AW-1:0]        diag_step;
  logic [AW-1:0]        prod;
  logic [AW-1:0]        addr;
  logic signed [DW-1:0] d_init;
  logic signed [DW-1:0] inc_diag;
  logic signed [DW-1:0] inc_straight;
  logic signed [DW-1:0] d;
  logic [XW-1:0]        cnt;

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      write_ok     <= start_ok;
      oor          <= !(start_ok && end_ok);
      major        <= major_c;
      maj_step     <= row_major ? row_step : col_step;
      min_step     <= row_major ? col_step : row_step;
      d_init       <= d_init_c;
      inc_diag     <= inc_diag_c;
      inc_straight <= inc_straight_c;
      prod         <= AW'(item_q.start_row) * AW'(cols_eff);
    end
    if (ctrl.base) begin
      addr      <= prod + AW'(item_q.start_col);
      diag_step <= maj_step + min_step;
      d         <= d_init;
      cnt       <= '0;
    end else if (ctrl.step) begin
      // minor axis moves when the decision term is zero or more
      if (!d[DW-1]) begin
        addr <= addr + diag_step;
        d    <= d + inc_diag;
      end else begin
        addr <= addr + maj_step;
        d    <= d + inc_straight;
      end
      cnt <= cnt + XW'(1);
    end
  end

  logic mem [DEPTH];
  logic rd_bit;
  logic chk;
  logic clear;

  always_ff @(posedge clk) begin
    if (ctrl.mem_write) mem[addr] <= item_q.occupied;
    if (ctrl.step) rd_bit <= mem[addr];
  end

  // read data is registered; chk is the step strobe delayed to match it
  always_ff @(posedge clk) begin
    if (rst) begin
      chk <= 1'b0;
    end else begin
      chk <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.base) begin
      clear <= 1'b1;
    end else if (chk && rd_bit) begin
      clear <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      res.line_clear   <= clear && !oor;
      res.out_of_range <= oor;
    end
  end

  always_comb begin
    status.is_write = item_q.kind == glos_pkg::KIND_WRITE;
    status.write_ok = write_ok;
    status.oor      = oor;
    status.last     = cnt == major;
    status.res_free = !res_valid || !res_stall;
  end

endmodule

FILE: sv/grid_line_of_sight_check_unit.sv
// Grid line-of-sight checker.
// cmd channel (cmd_valid / cmd_stall / cmd): one transaction either writes one
// occupancy cell (kind = write) or asks whether the straight grid line between
// two endpoints is free of obstacles (kind = query).
// res channel (res_valid / res_stall / res): one transaction per query, none
// per write. An endpoint outside the configured grid gives out_of_range = 1.
// cfg port: cfg_we with cfg_index 0 = row_count, 1 = col_count; it must be
// written only while the block is idle, which the block does not enforce.
// col_count is also the row stride of the map. A write occupies the block
// through CALC, BASE and WRITE, and skips WRITE when its cell falls outside the
// grid. A query walks the line one map cell per cycle through the single
// map port, over N = max(|drow|, |dcol|) + 1 cells, in CALC, BASE, WALK,
// DRAIN and FINISH; an out-of-range query goes from BASE to FINISH. One
// transaction is worked on at a time; cmd_stall is low only when idle.
// Reset clears the control logic and sets both counts to 256; the map itself
// is not cleared and must be written before it is read. A stalled result is
// held in the output register; a following query waits at its end until the
// register is free.
module grid_line_of_sight_check_unit #(
  parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = glos_pkg::MAP_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  glos_pkg::item_t                  cmd,
  output logic                             res_valid,
  input  logic                             res_stall,
  output glos_pkg::result_t                res,
  input  logic                             cfg_we,
  input  logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]       cfg_data
);

  glos_pkg::ctrl_t   ctrl;
  glos_pkg::status_t status;

  glos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  glos_datapath #(
    .MAP_ROWS (MAP_ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_no_accept_while_walking: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> cmd_stall)
    else $error("cmd accepted while a line walk is in progress");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> !(res_valid && res_stall))
    else $error("result register overwritten while stalled");

  a_oor_is_blocked: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_of_range |-> !res.line_clear)
    else $error("out-of-range query reported as clear");

  a_write_no_walk: assert property (@(posedge clk) disable iff (rst)
    ctrl.mem_write |=> !ctrl.step && cmd_stall == 1'b0)
    else $error("map write not followed by return to idle");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam logic KIND_QUERY  = ~glos_pkg::KIND_WRITE;
  localparam int   CELLS       = glos_pkg::MAP_ROWS_DEF * glos_pkg::MAP_COLS_DEF;
  localparam int   HOLD_CYCLES = 400;
  localparam int   SETTLE      = 8;
  localparam int   DRAIN       = 300;
  localparam int   LIMIT       = 3000000;

  typedef int unsigned cell_list_t[$];

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cmd_valid = 1'b0;
  logic                             cmd_stall;
  glos_pkg::item_t                  cmd = '0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  glos_pkg::result_t                res;
  logic                             cfg_we = 1'b0;
  logic [glos_pkg::CFG_INDEX_W-1:0] cfg_index = glos_pkg::REG_ROW_COUNT;
  logic [glos_pkg::CFG_W-1:0]       cfg_data = '0;

  // shadow of the block's configuration and map
  logic [glos_pkg::CFG_W-1:0] row_reg = glos_pkg::ROW_COUNT_RST;
  logic [glos_pkg::CFG_W-1:0] col_reg = glos_pkg::COL_COUNT_RST;
  bit               shadow_map     [0:CELLS-1];
  bit               shadow_written [0:CELLS-1];

  glos_pkg::result_t pending_sight[$];

  int  obstacle_pct = 0;
  bit  quiet = 1'b0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  writes_sent = 0;
  int  queries_checked = 0;
  int  clear_seen = 0;
  int  oor_seen = 0;
  int  grid_settings = 0;
  int  fail_count = 0;

  grid_line_of_sight_check_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int grid_rows();
    if (row_reg == 0) return 1;
    if (row_reg > glos_pkg::MAP_ROWS_DEF) return glos_pkg::MAP_ROWS_DEF;
    return int'(row_reg);
  endfunction

  function automatic int grid_cols();
    if (col_reg == 0) return 1;
    if (col_reg > glos_pkg::MAP_COLS_DEF) return glos_pkg::MAP_COLS_DEF;
    return int'(col_reg);
  endfunction

  function automatic bit in_grid(int sr, int sc, int er, int ec);
    return sr < grid_rows() && sc < grid_cols() && er < grid_rows() && ec < grid_cols();
  endfunction

  // Bresenham walk, endpoints included; ties on the delta go to the column axis
  function automatic cell_list_t trace_line(int sr, int sc, int er, int ec, int stride);
    cell_list_t  cells;
    int unsigned pos;
    int dr, dc, rs, cs, major, minor, mr, mc, nr, nc, d, m, i;
    dr = er - sr;
    dc = ec - sc;
    rs = (dr > 0) ? 1 : -1;
    cs = (dc > 0) ? 1 : -1;
    dr = (dr < 0) ? -dr : dr;
    dc = (dc < 0) ? -dc : dc;
    if (dr > dc) begin
      major = dr; minor = dc; mr = rs; mc = 0; nr = 0; nc = cs;
    end else begin
      major = dc; minor = dr; mr = 0; mc = cs; nr = rs; nc = 0;
    end
    d = 2 * minor - major;
    m = 0;
    for (i = 0; i <= major; i++) begin
      pos   = (sr + i * mr + m * nr) * stride + (sc + i * mc + m * nc);
      cells = {cells, pos};
      if (d >= 0) begin
        m++;
        d -= 2 * major;
      end
      d += 2 * minor;
    end
    return cells;
  endfunction

  function automatic glos_pkg::result_t predict_sight(glos_pkg::item_t it);
    glos_pkg::result_t r;
    cell_list_t        cells;
    if (!in_grid(it.start_row, it.start_col, it.end_row, it.end_col)) begin
      r.line_clear   = 1'b0;
      r.out_of_range = 1'b1;
      return r;
    end
    r.line_clear   = 1'b1;
    r.out_of_range = 1'b0;
    cells = trace_line(it.start_row, it.start_col, it.end_row, it.end_col, grid_cols());
    foreach (cells[k])
      if (shadow_map[cells[k]]) r.line_clear = 1'b0;
    return r;
  endfunction

  function automatic glos_pkg::item_t make_item(logic kind, int sr, int sc, int er, int ec,
                                                int occ);
    glos_pkg::item_t it;
    it.kind      = kind;
    it.start_row = sr[glos_pkg::COORD_W-1:0];
    it.start_col = sc[glos_pkg::COORD_W-1:0];
    it.end_row   = er[glos_pkg::COORD_W-1:0];
    it.end_col   = ec[glos_pkg::COORD_W-1:0];
    it.occupied  = occ[0];
    return it;
  endfunction

  // one command transaction; valid stays up for a back-to-back follower
  task automatic send_item(glos_pkg::item_t it);
    int                idx;
    glos_pkg::result_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
    if (it.kind == glos_pkg::KIND_WRITE) begin
      writes_sent++;
      if (it.start_row < grid_rows() && it.start_col < grid_cols()) begin
        idx = it.start_row * grid_cols() + it.start_col;
        shadow_map[idx]     = it.occupied;
        shadow_written[idx] = 1'b1;
      end
    end else begin
      predicted     = predict_sight(it);
      pending_sight = {pending_sight, predicted};
    end
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pending_sight.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [glos_pkg::CFG_INDEX_W-1:0] index,
                           logic [glos_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    if (index == glos_pkg::REG_ROW_COUNT) row_reg = value;
    else if (index == glos_pkg::REG_COL_COUNT) col_reg = value;
  endtask

  task automatic set_grid(int rows, int cols);
    wait_idle();
    write_reg(glos_pkg::REG_ROW_COUNT, rows[glos_pkg::CFG_W-1:0]);
    write_reg(glos_pkg::REG_COL_COUNT, cols[glos_pkg::CFG_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
    grid_settings++;
  endtask

  // a query on a line whose cells are not all loaded gets them written first
  task automatic issue_query(int sr, int sc, int er, int ec);
    cell_list_t cells;
    int         cols;
    cols = grid_cols();
    if (in_grid(sr, sc, er, ec)) begin
      cells = trace_line(sr, sc, er, ec, cols);
      foreach (cells[k])
        if (!shadow_written[cells[k]])
          send_item(make_item(glos_pkg::KIND_WRITE, cells[k] / cols, cells[k] % cols,
                              $urandom, $urandom, $urandom_range(0, 99) < obstacle_pct));
    end
    send_item(make_item(KIND_QUERY, sr, sc, er, ec, $urandom));
  endtask

  task automatic issue_window_query(int window);
    int sr, sc, er, ec, rmax, cmax;
    rmax = grid_rows() - 1;
    cmax = grid_cols() - 1;
    sr = $urandom_range(0, rmax);
    sc = $urandom_range(0, cmax);
    er = $urandom_range((sr > window) ? sr - window : 0,
                        (sr + window < rmax) ? sr + window : rmax);
    ec = $urandom_range((sc > window) ? sc - window : 0,
                        (sc + window < cmax) ? sc + window : cmax);
    issue_query(sr, sc, er, ec);
  endtask

  task automatic random_traffic(int count, int window);
    int base, pick, sr, sc, er, ec;
    base = items_sent;
    while (items_sent - base < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        issue_window_query(window);
      end else if (pick < 75) begin
        sr = $urandom_range(0, 255);
        sc = $urandom_range(0, 255);
        er = $urandom_range(0, 255);
        ec = $urandom_range(0, 255);
        if (in_grid(sr, sc, er, ec)) issue_window_query(window);
        else issue_query(sr, sc, er, ec);
      end else if (pick < 88) begin
        // anywhere: outside the grid this is dropped by the block
        send_item(make_item(glos_pkg::KIND_WRITE, $urandom, $urandom, $urandom, $urandom,
                            $urandom));
      end else begin
        send_item(make_item(glos_pkg::KIND_WRITE, $urandom_range(0, grid_rows() - 1),
                            $urandom_range(0, grid_cols() - 1), $urandom, $urandom,
                            $urandom_range(0, 99) < obstacle_pct));
      end
    end
  endtask

  task automatic test_reset_grid();
    obstacle_pct = 0;
    issue_query(0, 0, 0, 0);
    send_item(make_item(glos_pkg::KIND_WRITE, 255, 255, 0, 0, 1));
    issue_query(255, 255, 255, 255);
    issue_query(255, 0, 255, 3);
  endtask

  task automatic test_line_shapes();
    set_grid(16, 16);
    obstacle_pct = 0;
    issue_query(0, 0, 9, 2);    // steep, rows major
    issue_query(2, 0, 4, 11);   // shallow
    issue_query(3, 3, 8, 8);    // equal deltas pick columns
    issue_query(12, 14, 1, 3);  // walking backwards
    issue_query(0, 0, 1, 2);    // decision term starts at zero
    send_item(make_item(glos_pkg::KIND_WRITE, 5, 5, 0, 0, 1));
    issue_query(3, 3, 8, 8);
  endtask

  task automatic test_grid_bounds();
    set_grid(0, 511);           // clamps to 1 x 256
    issue_query(1, 0, 0, 0);
    issue_query(0, 250, 0, 255);
    send_item(make_item(glos_pkg::KIND_WRITE, 3, 3, 0, 0, 1));
    set_grid(300, 8);
    issue_query(0, 8, 0, 0);
    issue_query(255, 0, 255, 7);
    send_item(make_item(glos_pkg::KIND_WRITE, 2, 3, 0, 0, 0));
    set_grid(2, 8);
    send_item(make_item(glos_pkg::KIND_WRITE, 2, 3, 0, 0, 1));
    set_grid(256, 8);
    issue_query(2, 3, 2, 3);
  endtask

  task automatic test_stride_change();
    set_grid(16, 16);
    send_item(make_item(glos_pkg::KIND_WRITE, 1, 0, 0, 0, 1));
    set_grid(16, 8);            // same cell now sits at row 2
    issue_query(2, 0, 2, 0);
    issue_query(2, 0, 2, 3);
  endtask

  // full-length row, then the same cells walked as a column with stride 1
  task automatic test_long_lines();
    set_grid(256, 256);
    obstacle_pct = 1;
    issue_query(0, 0, 0, 255);
    set_grid(256, 1);
    issue_query(255, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    set_grid(16, 16);
    obstacle_pct = 10;
    hold_requests <= hold_requests + 1;
    repeat (8) issue_window_query(8);
    wait_idle();
  endtask

  task automatic test_random_grids();
    set_grid(16, 16);   obstacle_pct = 5;  random_traffic(130, 15);
    set_grid(1, 256);   obstacle_pct = 2;  random_traffic(90, 40);
    set_grid(256, 1);   obstacle_pct = 3;  random_traffic(90, 40);
    set_grid(0, 0);     obstacle_pct = 50; random_traffic(20, 1);
    set_grid(256, 256); obstacle_pct = 10; random_traffic(120, 5);
    set_grid(37, 200);  obstacle_pct = 20; random_traffic(90, 20);
  endtask

  task automatic test_quiet_tail();
    set_grid(64, 64);
    obstacle_pct = 4;
    quiet <= 1'b1;
    random_traffic(70, 10);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (quiet) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    glos_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_sight.size() == 0) begin
        fail_count++;
        $display("%0t: result transaction with nothing pending: clear=%0b oor=%0b",
                 $time, res.line_clear, res.out_of_range);
      end else begin
        want = pending_sight.pop_front();
        queries_checked++;
        clear_seen += want.line_clear;
        oor_seen   += want.out_of_range;
        if (res.line_clear !== want.line_clear) begin
          fail_count++;
          $display("%0t: line_clear expected %0b actual %0b",
                   $time, want.line_clear, res.line_clear);
        end
        if (res.out_of_range !== want.out_of_range) begin
          fail_count++;
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.out_of_range, res.out_of_range);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_grid();
    test_line_shapes();
    test_grid_bounds();
    test_stride_change();
    test_long_lines();
    test_backpressure();
    test_random_grids();
    test_quiet_tail();
    cmd_valid <= 1'b0;
    while (pending_sight.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d queries: %0d clear, %0d blocked in grid, %0d outside grid",
             queries_checked, clear_seen, queries_checked - clear_seen - oor_seen, oor_seen);
    $display("Sent %0d cell writes over %0d grid settings, %0d errors",
             writes_sent, grid_settings, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
